>>> src/scoo_pkg.sv
// ----------------------------------------------------------------------------
// scoo_pkg
// Shared types and constants of the sorted sparse coordinate-list merge block.
// ----------------------------------------------------------------------------
package scoo_pkg;

    localparam int DEFAULT_FIFO_DEPTH = 16;

    localparam int ROW_W   = 16;
    localparam int COL_W   = 16;
    localparam int VALUE_W = 32;
    localparam int NCOL_W  = 17;
    localparam int ENTRY_W = ROW_W + COL_W + VALUE_W;
    localparam int PROD_W  = ROW_W + NCOL_W;
    localparam int KEY_W   = PROD_W + 1;

    localparam logic [NCOL_W-1:0] NUM_COLS_RESET = 17'h10000;

    // Input item codes
    localparam logic [1:0] FUNC_FIRST_ENTRY  = 2'd0;
    localparam logic [1:0] FUNC_SECOND_ENTRY = 2'd1;
    localparam logic [1:0] FUNC_FIRST_END    = 2'd2;
    localparam logic [1:0] FUNC_SECOND_END   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_READ,
        ST_MUL,
        ST_DECIDE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic latch;      // capture the accepted input item
        logic apply;      // store the entry or set the end flag
        logic emit_drop;  // load a drop notice into the output register
        logic pop_emit;   // emit the merged head and pop its FIFO(s)
        logic notice;     // emit the empty-merge notice
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic drop;          // latched entry cannot be stored
        logic out_free;      // output register can take a result
        logic decidable;     // a merged entry may be emitted now
        logic empty_notice;  // both lists ended with nothing pending
    } t_dp_status;

endpackage

>>> src/sparse_coo_sorted_merge_add_core.sv
// ----------------------------------------------------------------------------
// sparse_coo_sorted_merge_add_core
// Merge of two sorted sparse coordinate lists into one sorted sum list.
// ----------------------------------------------------------------------------
// Items of two coordinate lists, each sorted by the key row*num_cols+col, and
// one end marker per list arrive on the input channel, tagged by i_func. Each
// entry waits in a FIFO of its own side (FIFO_DEPTH entries, block RAM with
// registered read). The block then emits, one result per transfer, the smaller
// of the two FIFO heads; equal keys give one entry whose value is the wrapping
// 32-bit sum, with the first list's coordinates. An entry is held back until it
// is known whether it is the final one; the final entry carries o_last and
// re-arms the block for a new merge. Two end markers with nothing pending give
// one non-entry result with o_last set. An entry that finds its FIFO full, or
// its list already ended, is not stored and comes back as a drop notice
// (o_dropped, coordinates and value echoed).
// Timing: one item is taken at a time. Accepting and storing an item are
// separate steps; each merged result then passes RAM head read, key multiply,
// and compare and emit, and one closing pass finds nothing more to emit or
// emits the empty-merge notice. The emit step waits while the output stalls.
// A drop notice is loaded in place of the store step, with no merge pass, once
// the output register is free. num_cols may be written through i_cfg_we at
// any idle time; it resets to 65536.
// ----------------------------------------------------------------------------
module sparse_coo_sorted_merge_add_core
    import scoo_pkg::*;
#(
    parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [NCOL_W-1:0]         i_cfg_data,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_func,
    input  logic [ROW_W-1:0]          i_row,
    input  logic [COL_W-1:0]          i_col,
    input  logic signed [VALUE_W-1:0] i_value,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [ROW_W-1:0]          o_out_row,
    output logic [COL_W-1:0]          o_out_col,
    output logic signed [VALUE_W-1:0] o_out_value,
    output logic                      o_is_entry,
    output logic                      o_last,
    output logic                      o_dropped
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // sequencer: accept, apply, then step the merge until nothing is decidable
    scoo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // FIFOs, key compare and the output register that holds each transfer
    scoo_dp #(.FIFO_DEPTH(FIFO_DEPTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_func      (i_func),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_out_value (o_out_value),
        .o_is_entry  (o_is_entry),
        .o_last      (o_last),
        .o_dropped   (o_dropped)
    );

endmodule

>>> src/scoo_ram.sv
// ----------------------------------------------------------------------------
// scoo_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module scoo_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/scoo_ctrl.sv
// ----------------------------------------------------------------------------
// scoo_ctrl
// Sequencer: take one item, apply it, then step the merge one result at a time.
// ----------------------------------------------------------------------------
module scoo_ctrl
    import scoo_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (i_status.drop) begin
                    // hold until the output register frees up
                    if (i_status.out_free) begin
                        o_cmd.emit_drop = 1'b1;
                        n_state         = ST_IDLE;
                    end
                end else begin
                    o_cmd.apply = 1'b1;
                    n_state     = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (i_status.decidable) begin
                    if (i_status.out_free) begin
                        o_cmd.pop_emit = 1'b1;
                        n_state        = ST_READ;
                    end
                end else if (i_status.empty_notice) begin
                    if (i_status.out_free) begin
                        o_cmd.notice = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/scoo_dp.sv
// ----------------------------------------------------------------------------
// scoo_dp
// Datapath: two entry FIFOs, key multipliers, head compare and output register.
// ----------------------------------------------------------------------------
module scoo_dp
    import scoo_pkg::*;
#(
    parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [NCOL_W-1:0]         i_cfg_data,
    input  logic [1:0]                i_func,
    input  logic [ROW_W-1:0]          i_row,
    input  logic [COL_W-1:0]          i_col,
    input  logic signed [VALUE_W-1:0] i_value,
    input  t_dp_cmd                   i_cmd,
    output t_dp_status                o_status,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [ROW_W-1:0]          o_out_row,
    output logic [COL_W-1:0]          o_out_col,
    output logic signed [VALUE_W-1:0] o_out_value,
    output logic                      o_is_entry,
    output logic                      o_last,
    output logic                      o_dropped
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    // configuration and latched input
    logic [NCOL_W-1:0]  r_num_cols;
    logic [1:0]         r_func;
    logic [ENTRY_W-1:0] r_entry;

    // FIFO control
    logic [PTR_W-1:0] r_head_a, r_head_b, r_tail_a, r_tail_b;
    logic [CNT_W-1:0] r_cnt_a, r_cnt_b;
    logic             r_end_a, r_end_b;

    logic [ENTRY_W-1:0] rd_a, rd_b;
    logic               we_a, we_b;

    // key products
    logic [PROD_W-1:0] r_prod_a, r_prod_b;
    logic [KEY_W-1:0]  key_a, key_b;

    // output register
    logic               r_out_valid;
    logic [ROW_W-1:0]   r_out_row;
    logic [COL_W-1:0]   r_out_col;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_is_entry, r_last, r_dropped;

    logic               take_a, take_b, has_pick, remain_zero, both_end;
    logic [SUM_W-1:0]   total, taken;
    logic [ENTRY_W-1:0] pick;
    logic [VALUE_W-1:0] sum_value;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign we_a = i_cmd.apply && (r_func == FUNC_FIRST_ENTRY);
    assign we_b = i_cmd.apply && (r_func == FUNC_SECOND_ENTRY);

    scoo_ram #(.WIDTH(ENTRY_W), .DEPTH(FIFO_DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_tail_a),
        .i_wdata (r_entry),
        .i_raddr (r_head_a),
        .o_rdata (rd_a)
    );

    scoo_ram #(.WIDTH(ENTRY_W), .DEPTH(FIFO_DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_tail_b),
        .i_wdata (r_entry),
        .i_raddr (r_head_b),
        .o_rdata (rd_b)
    );

    // Register the row products; the heads stay put from head read to compare.
    always_ff @(posedge i_clk) begin
        r_prod_a <= PROD_W'(rd_a[ENTRY_W-1 -: ROW_W]) * PROD_W'(r_num_cols);
        r_prod_b <= PROD_W'(rd_b[ENTRY_W-1 -: ROW_W]) * PROD_W'(r_num_cols);
    end

    assign key_a = KEY_W'(r_prod_a) + KEY_W'(rd_a[VALUE_W +: COL_W]);
    assign key_b = KEY_W'(r_prod_b) + KEY_W'(rd_b[VALUE_W +: COL_W]);

    assign both_end = r_end_a && r_end_b;

    always_comb begin
        take_a = 1'b0;
        take_b = 1'b0;
        if (r_cnt_a != '0 && r_cnt_b != '0) begin
            take_a = (key_a <= key_b);
            take_b = (key_b <= key_a);
        end else if (r_cnt_a != '0 && r_end_b) begin
            take_a = 1'b1;
        end else if (r_cnt_b != '0 && r_end_a) begin
            take_b = 1'b1;
        end
    end

    assign has_pick    = take_a || take_b;
    assign total       = SUM_W'(r_cnt_a) + SUM_W'(r_cnt_b);
    assign taken       = SUM_W'(take_a) + SUM_W'(take_b);
    assign remain_zero = (total == taken);
    assign pick        = take_a ? rd_a : rd_b;
    assign sum_value   = rd_a[VALUE_W-1:0] + rd_b[VALUE_W-1:0];

    assign o_status.drop = ((r_func == FUNC_FIRST_ENTRY) && (r_end_a || r_cnt_a == CNT_FULL))
                        || ((r_func == FUNC_SECOND_ENTRY) && (r_end_b || r_cnt_b == CNT_FULL));
    assign o_status.out_free     = !r_out_valid || i_out_ready;
    assign o_status.decidable    = has_pick && (!remain_zero || both_end);
    assign o_status.empty_notice = both_end && r_cnt_a == '0 && r_cnt_b == '0;

    // control state: configuration, pointers, counts, end flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cols <= NUM_COLS_RESET;
            r_head_a   <= '0;
            r_head_b   <= '0;
            r_tail_a   <= '0;
            r_tail_b   <= '0;
            r_cnt_a    <= '0;
            r_cnt_b    <= '0;
            r_end_a    <= 1'b0;
            r_end_b    <= 1'b0;
            r_func     <= FUNC_FIRST_END;
        end else begin
            if (i_cfg_we) begin
                r_num_cols <= i_cfg_data;
            end
            if (i_cmd.latch) begin
                r_func <= i_func;
            end
            if (i_cmd.apply) begin
                case (r_func)
                    FUNC_FIRST_ENTRY: begin
                        r_tail_a <= ptr_inc(r_tail_a);
                        r_cnt_a  <= r_cnt_a + 1'b1;
                    end
                    FUNC_SECOND_ENTRY: begin
                        r_tail_b <= ptr_inc(r_tail_b);
                        r_cnt_b  <= r_cnt_b + 1'b1;
                    end
                    FUNC_FIRST_END: begin
                        r_end_a <= 1'b1;
                    end
                    FUNC_SECOND_END: begin
                        r_end_b <= 1'b1;
                    end
                    default: begin
                        r_end_a <= r_end_a;
                    end
                endcase
            end
            if (i_cmd.pop_emit) begin
                if (take_a) begin
                    r_head_a <= ptr_inc(r_head_a);
                    r_cnt_a  <= r_cnt_a - 1'b1;
                end
                if (take_b) begin
                    r_head_b <= ptr_inc(r_head_b);
                    r_cnt_b  <= r_cnt_b - 1'b1;
                end
                if (remain_zero) begin
                    r_end_a <= 1'b0;
                    r_end_b <= 1'b0;
                end
            end
            if (i_cmd.notice) begin
                r_end_a <= 1'b0;
                r_end_b <= 1'b0;
            end
        end
    end

    // latched payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_entry <= {i_row, i_col, i_value};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_drop || i_cmd.pop_emit || i_cmd.notice) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_drop) begin
            r_out_row   <= r_entry[ENTRY_W-1 -: ROW_W];
            r_out_col   <= r_entry[VALUE_W +: COL_W];
            r_out_value <= r_entry[VALUE_W-1:0];
            r_is_entry  <= 1'b0;
            r_last      <= 1'b0;
            r_dropped   <= 1'b1;
        end else if (i_cmd.pop_emit) begin
            r_out_row   <= pick[ENTRY_W-1 -: ROW_W];
            r_out_col   <= pick[VALUE_W +: COL_W];
            r_out_value <= (take_a && take_b) ? sum_value : pick[VALUE_W-1:0];
            r_is_entry  <= 1'b1;
            r_last      <= remain_zero;
            r_dropped   <= 1'b0;
        end else if (i_cmd.notice) begin
            r_out_row   <= '0;
            r_out_col   <= '0;
            r_out_value <= '0;
            r_is_entry  <= 1'b0;
            r_last      <= 1'b1;
            r_dropped   <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_value = r_out_value;
    assign o_is_entry  = r_is_entry;
    assign o_last      = r_last;
    assign o_dropped   = r_dropped;

endmodule
